// ----- hw/rtl/wbss_pkg.sv -----
package wbss_pkg;

   // signature geometry
   localparam int MAX_PATTERN    = 32;
   localparam int LEN_BITS       = 6;
   localparam int LEN_IDX_BITS   = $clog2(MAX_PATTERN);
   localparam int BYTE_BITS      = 8;
   localparam int WORD_BITS      = 64;
   localparam int BYTES_PER_WORD = WORD_BITS / BYTE_BITS;
   localparam int SIG_WORDS      = 4;

   // position counter and result offset
   localparam int POSITION_BITS  = 32;
   localparam int OFFSET_BITS    = 32;

   // register file
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_0_7    = 3'd1,
      CSR_PATTERN_8_15   = 3'd2,
      CSR_PATTERN_16_23  = 3'd3,
      CSR_PATTERN_24_31  = 3'd4,
      CSR_CARE_MASK      = 3'd5
   } csr_index_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic step;
      logic clear;
   } wbss_cell_ctl_type;

endpackage

// ----- hw/rtl/wildcard_byte_signature_scan.sv -----
// Wildcard byte signature scanner. Image bytes arrive one per transfer on the req_ channel,
// with req_last_byte marking the final byte of an image. The block looks for the first
// place where the signature (up to 32 bytes, set through the csr_ port, each byte either
// exact or a wildcard per care_mask) matches, and sends one rsp_ transfer with found = 1
// and the start offset of that match, or found = 0 and offset 0 on the final byte when no
// match occurred. After the final byte the scan rearms for the next image; the registers
// keep their values. Throughput is one byte per clock while req_stall is low: a row of 32
// cells holds the latest image bytes, each cell handing its byte to its neighbor on every
// transfer, and each cell compares the byte it is about to hold with the signature byte
// that lines up with it for the current length. The verdict for a byte is decided in the
// cycle it is taken, written into the output register at that edge and shown on rsp_ from
// the next cycle on. req_stall rises only while a result waits in the output register and
// the consumer stalls. csr_ready is always high; a register write takes effect from the
// next byte on, also in the middle of an image.
module wildcard_byte_signature_scan import wbss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // byte stream
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BYTE_BITS-1:0]      req_image_byte,
   input  logic                      req_last_byte,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [OFFSET_BITS-1:0]    rsp_match_offset,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // configuration registers
   logic [LEN_BITS-1:0]    pattern_length_ff;
   logic [WORD_BITS-1:0]   pattern_word_ff [SIG_WORDS];
   logic [MAX_PATTERN-1:0] care_mask_ff;

   // scan state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     reported_ff, reported_in;

   // cell row
   wbss_cell_ctl_type              cell_ctl;
   logic [SIG_WORDS*WORD_BITS-1:0] sig_flat;
   logic [LEN_IDX_BITS-1:0]        sig_idx    [MAX_PATTERN];
   logic [BYTE_BITS-1:0]           cell_sig   [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]         cell_care;
   logic [MAX_PATTERN-1:0]         cell_use;
   logic [BYTE_BITS-1:0]           shift_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]         shift_filled;
   logic [BYTE_BITS-1:0]           win_byte   [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]         win_filled;
   logic [MAX_PATTERN-1:0]         hit_now;

   logic                     req_accept;
   logic [LEN_IDX_BITS-1:0]  len_idx;
   logic                     win_hit;
   logic                     res_valid;
   logic                     res_found;
   logic [OFFSET_BITS-1:0]   res_offset;
   logic                     out_blocked;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_BITS'(1);
         for (int w = 0; w < SIG_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         care_mask_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_BITS-1:0];
            CSR_PATTERN_0_7:    pattern_word_ff[0] <= csr_data;
            CSR_PATTERN_8_15:   pattern_word_ff[1] <= csr_data;
            CSR_PATTERN_16_23:  pattern_word_ff[2] <= csr_data;
            CSR_PATTERN_24_31:  pattern_word_ff[3] <= csr_data;
            CSR_CARE_MASK:      care_mask_ff <= csr_data[MAX_PATTERN-1:0];
            default: ;
         endcase
      end
   end

   // a zero length acts as one, anything past the cell count as the full row
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_idx = '0;
      end else if (pattern_length_ff > LEN_BITS'(MAX_PATTERN)) begin
         len_idx = LEN_IDX_BITS'(MAX_PATTERN - 1);
      end else begin
         len_idx = LEN_IDX_BITS'(pattern_length_ff - LEN_BITS'(1));
      end
   end

   // input is held only while a result sits in the output register and is stalled
   assign req_stall  = out_blocked;
   assign req_accept = req_valid && !req_stall;

   assign cell_ctl.step  = req_accept;
   assign cell_ctl.clear = req_accept && req_last_byte;

   // signature bytes side by side, byte 0 lowest
   for (genvar w = 0; w < SIG_WORDS; w++) begin : g_word
      assign sig_flat[w*WORD_BITS +: WORD_BITS] = pattern_word_ff[w];
   end

   // cell 0 takes the incoming byte, the others their neighbor's
   assign shift_byte[0] = req_image_byte;
   assign shift_filled  = {win_filled[MAX_PATTERN-2:0], 1'b1};

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign shift_byte[k] = win_byte[k-1];
      end

      // window entry k lines up with signature byte len - 1 - k
      assign sig_idx[k]   = len_idx - LEN_IDX_BITS'(k);
      assign cell_use[k]  = (LEN_IDX_BITS'(k) <= len_idx);
      assign cell_sig[k]  = sig_flat[sig_idx[k] * BYTE_BITS +: BYTE_BITS];
      assign cell_care[k] = care_mask_ff[sig_idx[k]];

      wbss_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .shift_byte   (shift_byte[k]),
         .shift_filled (shift_filled[k]),
         .sig_byte     (cell_sig[k]),
         .care         (cell_care[k]),
         .in_use       (cell_use[k]),
         .match_now    (hit_now[k]),
         .byte_ff      (win_byte[k]),
         .filled_ff    (win_filled[k])
      );
   end

   // whole signature ends on the incoming byte when every cell agrees
   assign win_hit = &hit_now;

   // first match reports the start; otherwise not found on the final byte
   always_comb begin
      res_valid  = 1'b0;
      res_found  = 1'b0;
      res_offset = '0;
      if (req_accept && !reported_ff) begin
         if (win_hit) begin
            res_valid  = 1'b1;
            res_found  = 1'b1;
            res_offset = OFFSET_BITS'(pos_ff - POSITION_BITS'(len_idx));
         end else if (req_last_byte) begin
            res_valid = 1'b1;
         end
      end
   end

   // position saturates, everything rearms after the final byte
   always_comb begin
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            pos_in      = '0;
            reported_in = 1'b0;
         end else begin
            if (pos_ff != '1) begin
               pos_in = pos_ff + POSITION_BITS'(1);
            end
            if (res_found) begin
               reported_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         reported_ff <= reported_in;
      end
   end

   wbss_out_reg u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (res_valid),
      .found            (res_found),
      .offset           (res_offset),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .blocked          (out_blocked)
   );

   // final byte rearms position and report flag
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=> (pos_ff == '0 && !reported_ff))
      else $error("scan state not cleared after final byte");

   // the report flag is only raised by a found transfer
   a_report_source: assert property (@(posedge clock) disable iff (reset)
      $rose(reported_ff) |-> $past(res_valid && res_found))
      else $error("report flag set without a found result");

   // a new result never lands on a stalled one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(rsp_valid && rsp_stall))
      else $error("result produced while output register blocked");

   // not found always carries offset zero
   a_not_found_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_offset == '0))
      else $error("not found result with nonzero offset");

endmodule

// ----- hw/rtl/wbss_cell.sv -----
module wbss_cell import wbss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  wbss_cell_ctl_type    ctl,
   input  logic [BYTE_BITS-1:0] shift_byte,
   input  logic                 shift_filled,
   input  logic [BYTE_BITS-1:0] sig_byte,
   input  logic                 care,
   input  logic                 in_use,
   output logic                 match_now,
   output logic [BYTE_BITS-1:0] byte_ff,
   output logic                 filled_ff
);

   logic [BYTE_BITS-1:0] byte_in;
   logic                 filled_in;

   // the byte this cell holds after the shift agrees with its signature byte
   assign match_now = !in_use || (shift_filled && (!care || (shift_byte == sig_byte)));

   always_comb begin
      byte_in   = byte_ff;
      filled_in = filled_ff;
      if (ctl.clear) begin
         byte_in   = '0;
         filled_in = 1'b0;
      end else if (ctl.step) begin
         byte_in   = shift_byte;
         filled_in = shift_filled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff   <= '0;
         filled_ff <= 1'b0;
      end else begin
         byte_ff   <= byte_in;
         filled_ff <= filled_in;
      end
   end

endmodule

// ----- hw/rtl/wbss_out_reg.sv -----
module wbss_out_reg import wbss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   found,
   input  logic [OFFSET_BITS-1:0] offset,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_found,
   output logic [OFFSET_BITS-1:0] rsp_match_offset,
   output logic                   blocked
);

   logic                   valid_ff, valid_in;
   logic                   found_ff;
   logic [OFFSET_BITS-1:0] offset_ff;

   assign blocked = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         found_ff  <= found;
         offset_ff <= offset;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule
